// ===== rtl/mcba_pkg.sv =====
// shared constants, types and sizing for the round-robin block averager
// no dependencies; imported by mcba_bank, multichannel_adc_block_averager_core and its testbench
package mcba_pkg;

  localparam int SENSORS      = 4;
  localparam int SAMPLE_COUNT = 8;
  localparam int SAMPLE_BITS  = 16;

  // port field widths, fixed by the stream format
  localparam int QRY_W       = 8;
  localparam int SENS_PORT_W = 4;
  localparam int VAL_W       = 16;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 24;

  localparam int SIDX_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int RND_W   = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int CNT_LOG = $clog2(SAMPLE_COUNT);

  // a block sum never exceeds SAMPLE_COUNT full-scale samples
  localparam int SUM_W = SAMPLE_BITS + CNT_LOG;

  // floor(sum / SAMPLE_COUNT) as (sum * RECIP) >> RECIP_SH, exact for every SUM_W-bit sum
  localparam int RECIP_SH = SUM_W + CNT_LOG;
  localparam int RECIP_W  = SUM_W + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SH) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic              add_en;
    logic [SIDX_W-1:0] chan;
    logic              latch;
  } mcba_acc_ctl_t;

endpackage

// ===== rtl/mcba_bank.sv =====
// per-channel running sums, latched block sums and the average read path
// depends on mcba_pkg
module mcba_bank
  import mcba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  mcba_acc_ctl_t          ctl,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SIDX_W-1:0]      rd_chan,
  output logic [SAMPLE_BITS-1:0] rd_avg
);

  logic [SUM_W-1:0]  sum_r   [SENSORS];
  logic [SUM_W-1:0]  sum_nxt [SENSORS];
  logic [SUM_W-1:0]  blk_r   [SENSORS];
  logic [SUM_W-1:0]  blk_nxt [SENSORS];
  logic [SUM_W-1:0]  added   [SENSORS];
  logic [PROD_W-1:0] prod;

  always_comb begin
    for (int ch = 0; ch < SENSORS; ch++) begin
      if (ctl.add_en && (ctl.chan == SIDX_W'(ch))) begin
        added[ch] = sum_r[ch] + SUM_W'(sample);
      end else begin
        added[ch] = sum_r[ch];
      end
      // end of block: the completed sums move over and the running sums clear
      if (ctl.latch) begin
        blk_nxt[ch] = added[ch];
        sum_nxt[ch] = '0;
      end else begin
        blk_nxt[ch] = blk_r[ch];
        sum_nxt[ch] = added[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ch = 0; ch < SENSORS; ch++) begin
        sum_r[ch] <= '0;
        blk_r[ch] <= '0;
      end
    end else begin
      for (int ch = 0; ch < SENSORS; ch++) begin
        sum_r[ch] <= sum_nxt[ch];
        blk_r[ch] <= blk_nxt[ch];
      end
    end
  end

  // constant divide by reciprocal multiply
  assign prod   = PROD_W'(blk_r[rd_chan]) * PROD_W'(RECIP);
  assign rd_avg = prod[RECIP_SH +: SAMPLE_BITS];

endmodule

// ===== rtl/multichannel_adc_block_averager_core.sv =====
// round-robin multichannel block averager, top level
// depends on mcba_pkg and mcba_bank
//
//  port group | dir | tdata (low bit up)                         | tuser / tlast
//  in_*       | in  | sample_value[15:0], query_sensor[23:16]    | tuser: cmd
//  out_*      | out | stored_sensor[3:0], next_sensor[7:4],      | tlast: round_done
//             |     | read_value[23:8]                           |
//
//  one item per cycle sustained while out_tready stays high; an item enters the input register at
//  its transfer edge, and its result then moves on into the result register, which drives the
//  out transfer
//  the sum update and the reciprocal multiply of the average read sit between those registers
//  synchronous active-low reset clears sums, averages, channel and round counters
//  a stalled result holds in the output register while one more item waits in the input register

module multichannel_adc_block_averager_core
  import mcba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample_value, query_sensor
  input  logic                  in_tuser,   // cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // stored_sensor, next_sensor, read_value
  output logic                  out_tlast   // round_done
);

  logic                   in_valid_r;
  logic                   in_cmd_r;
  logic [SAMPLE_BITS-1:0] in_sample_r;
  logic [QRY_W-1:0]       in_query_r;

  logic [SIDX_W-1:0]      sidx_r, sidx_nxt;
  logic [RND_W-1:0]       rnd_r, rnd_nxt;

  logic                   out_valid_r;
  logic [SENS_PORT_W-1:0] out_stored_r, out_stored_nxt;
  logic [SENS_PORT_W-1:0] out_next_r, out_next_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [VAL_W-1:0]       out_value_r, out_value_nxt;

  logic                   advance;
  logic                   fire;
  logic                   is_sample;
  logic                   chan_last;
  logic                   rnd_last;
  logic                   q_in_range;
  logic [SAMPLE_BITS-1:0] rd_avg;
  mcba_acc_ctl_t          acc_ctl;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign fire      = in_valid_r && advance;
  assign is_sample = (in_cmd_r == CMD_SAMPLE);
  assign chan_last = (sidx_r == SIDX_W'(SENSORS - 1));
  assign rnd_last  = (rnd_r == RND_W'(SAMPLE_COUNT - 1));
  assign q_in_range = (in_query_r < QRY_W'(SENSORS));

  assign acc_ctl.add_en = fire && is_sample;
  assign acc_ctl.chan   = sidx_r;
  assign acc_ctl.latch  = fire && is_sample && chan_last && rnd_last;

  always_comb begin
    sidx_nxt = sidx_r;
    rnd_nxt  = rnd_r;
    if (fire && is_sample) begin
      if (chan_last) begin
        sidx_nxt = '0;
        rnd_nxt  = rnd_last ? '0 : rnd_r + RND_W'(1);
      end else begin
        sidx_nxt = sidx_r + SIDX_W'(1);
      end
    end
  end

  always_comb begin
    out_next_nxt = SENS_PORT_W'(sidx_nxt);
    if (is_sample) begin
      out_stored_nxt = SENS_PORT_W'(sidx_r);
      out_last_nxt   = chan_last && rnd_last;
      out_value_nxt  = '0;
    end else begin
      out_stored_nxt = '0;
      out_last_nxt   = 1'b0;
      out_value_nxt  = q_in_range ? VAL_W'(rd_avg) : '0;
    end
  end

  mcba_bank u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (acc_ctl),
    .sample  (in_sample_r),
    .rd_chan (in_query_r[SIDX_W-1:0]),
    .rd_avg  (rd_avg)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sidx_r      <= '0;
      rnd_r       <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      sidx_r <= sidx_nxt;
      rnd_r  <= rnd_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r    <= in_tuser;
      in_sample_r <= in_tdata[SAMPLE_BITS-1:0];
      in_query_r  <= in_tdata[16 +: QRY_W];
    end
    if (fire) begin
      out_stored_r <= out_stored_nxt;
      out_next_r   <= out_next_nxt;
      out_last_r   <= out_last_nxt;
      out_value_r  <= out_value_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_value_r, out_next_r, out_stored_r};
  assign out_tlast  = out_last_r;

  // a completed block always ends on the last channel and wraps back to channel zero
  a_done_last_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |->
      (out_stored_r == SENS_PORT_W'(SENSORS - 1)) && (out_next_r == '0))
    else $error("round_done without channel wrap");

  // channel counter stays inside the sensor range
  a_sidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    sidx_r <= SIDX_W'(SENSORS - 1))
    else $error("channel index out of range");

  // a waiting item is neither dropped nor consumed while the result side stalls
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_query_r) && $stable(in_cmd_r))
    else $error("input register lost an item during stall");

  // counters move only on a sample transfer into the result register
  a_counter_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && is_sample) |=> $stable(sidx_r) && $stable(rnd_r))
    else $error("counters moved without a sample");

endmodule

// ===== test/multichannel_adc_block_averager_core_test.sv =====
// testbench for multichannel_adc_block_averager_core: streams samples and average queries,
// predicts every result with a scoreboard class and checks each out transfer field by field
// depends on mcba_pkg and the core rtl only
`timescale 1ns / 100ps

module multichannel_adc_block_averager_core_test
  import mcba_pkg::*;
();

  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 5000;
  localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 1);

  typedef struct packed {
    logic [3:0]  stored_sensor;
    logic [3:0]  next_sensor;
    logic        round_done;
    logic [15:0] read_value;
  } avg_result_t;

  class block_average_tracker;
    logic [3:0]  sensor_index;
    logic [7:0]  round_index;
    logic [23:0] channel_sum [SENSORS];
    logic [15:0] channel_average [SENSORS];
    avg_result_t due_results [$];
    int          errors, checked, samples, queries, out_of_range, blocks;

    function new();
      sensor_index = '0;
      round_index  = '0;
      for (int ch = 0; ch < SENSORS; ch++) begin
        channel_sum[ch]     = '0;
        channel_average[ch] = '0;
      end
      errors = 0; checked = 0; samples = 0; queries = 0; out_of_range = 0; blocks = 0;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 30) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // accepted in transfer: advance the channel state and queue the result it must give
    function void take_item(input logic cmd, input logic [IN_DATA_W-1:0] data);
      logic [15:0] smp;
      logic [7:0]  qry;
      avg_result_t res;
      int          cur;
      smp = data[15:0] & SAMPLE_MASK;
      qry = data[23:16];
      res = '0;
      if (cmd == CMD_SAMPLE) begin
        samples++;
        cur = sensor_index;
        if (cur >= SENSORS) cur = 0;
        channel_sum[cur] = channel_sum[cur] + 24'(smp);
        res.stored_sensor = 4'(cur);
        cur++;
        if (cur >= SENSORS) begin
          cur = 0;
          round_index = round_index + 8'd1;
          if (round_index >= SAMPLE_COUNT) begin
            round_index = '0;
            for (int ch = 0; ch < SENSORS; ch++) begin
              channel_average[ch] = 16'(channel_sum[ch] / SAMPLE_COUNT);
              channel_sum[ch]     = '0;
            end
            res.round_done = 1'b1;
            blocks++;
          end
        end
        sensor_index = 4'(cur);
      end else begin
        queries++;
        if (qry < SENSORS) res.read_value = channel_average[qry];
        else out_of_range++;
      end
      res.next_sensor = sensor_index;
      due_results.push_back(res);
    endfunction

    task check_result(input logic [OUT_DATA_W-1:0] data, input logic last);
      avg_result_t exp_res;
      checked++;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result tdata=%h tlast=%b", data, last));
      end else begin
        exp_res = due_results.pop_front();
        if (data[3:0] !== exp_res.stored_sensor)
          report($sformatf("result %0d stored_sensor %0d, expected %0d",
                           checked, data[3:0], exp_res.stored_sensor));
        if (data[7:4] !== exp_res.next_sensor)
          report($sformatf("result %0d next_sensor %0d, expected %0d",
                           checked, data[7:4], exp_res.next_sensor));
        if (last !== exp_res.round_done)
          report($sformatf("result %0d round_done %b, expected %b",
                           checked, last, exp_res.round_done));
        if (data[23:8] !== exp_res.read_value)
          report($sformatf("result %0d read_value %h, expected %h",
                           checked, data[23:8], exp_res.read_value));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // sample_value, query_sensor
  logic                  in_tuser;   // cmd
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // stored_sensor, next_sensor, read_value
  logic                  out_tlast;  // round_done

  block_average_tracker tracker;
  bit src_calm, sink_calm, hold_request;

  multichannel_adc_block_averager_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // offer one item, wait for its transfer, then maybe leave a gap
  task automatic send_item(input logic cmd, input logic [IN_DATA_W-1:0] data);
    int gap, r;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_item(cmd, data);
    gap = 0;
    if (!src_calm) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(8, 30);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : result_sink
    int stall_left, r;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) tracker.check_result(out_tdata, out_tlast);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (sink_calm) begin
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(7, 29);
        end
      end
    end
  end

  initial begin
    logic [IN_DATA_W-1:0] data;
    logic                 cmd;
    int                   flavor, waited;
    tracker      = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = CMD_SAMPLE;
    out_tready   = 1'b0;
    src_calm     = 1'b0;
    sink_calm    = 1'b0;
    hold_request = 1'b0;
    flavor       = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // averages read as zero before any block, range edges of the query index
    send_item(CMD_QUERY,  {8'd0, 16'h0000});
    send_item(CMD_QUERY,  {8'(SENSORS - 1), 16'hffff});
    send_item(CMD_QUERY,  {8'(SENSORS), 16'h0000});
    send_item(CMD_QUERY,  {8'hff, 16'h1234});
    send_item(CMD_QUERY,  {8'h80, 16'h0000});
    send_item(CMD_QUERY,  {8'h7f, 16'hffff});
    // full-scale, zero and alternating samples; query field must be ignored
    send_item(CMD_SAMPLE, {8'h00, 16'hffff});
    send_item(CMD_SAMPLE, {8'hff, 16'h0000});
    send_item(CMD_QUERY,  {8'd1, 16'h0000});
    send_item(CMD_SAMPLE, {8'h55, 16'haaaa});
    send_item(CMD_SAMPLE, {8'haa, 16'h5555});
    // queries leave the channel position alone
    send_item(CMD_QUERY,  {8'd2, 16'hffff});
    send_item(CMD_QUERY,  {8'd0, 16'h0000});
    send_item(CMD_SAMPLE, {8'h00, 16'h8000});
    send_item(CMD_SAMPLE, {8'h00, 16'h0001});

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        src_calm  = ($urandom_range(0, 3) == 0);
        sink_calm = ($urandom_range(0, 3) == 0);
      end
      if (n == HOLD_AT) begin
        // long receiver stall while items keep coming, so the core backs up
        src_calm     = 1'b1;
        hold_request = 1'b1;
      end
      data = IN_DATA_W'($urandom());
      if ($urandom_range(0, 3) == 0) begin
        cmd = CMD_QUERY;
        if ($urandom_range(0, 9) < 7) data[23:16] = 8'($urandom_range(0, SENSORS - 1));
      end else begin
        cmd = CMD_SAMPLE;
        // pick a value style per block so full-scale and zero averages come up
        if (tracker.sensor_index == 0 && tracker.round_index == 0)
          flavor = $urandom_range(0, 3);
        case (flavor)
          1: data[15:0] = 16'hffff;
          2: data[15:0] = 16'h0000;
          3: data[15:12] = 4'hf;
          default: ;
        endcase
      end
      send_item(cmd, data);
    end
    in_tvalid <= 1'b0;

    waited = 0;
    while (tracker.due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (tracker.due_results.size() != 0)
      tracker.report($sformatf("%0d expected results never arrived",
                               tracker.due_results.size()));

    $display("covered %0d samples over %0d latched blocks, %0d queries (%0d out of range)",
             tracker.samples, tracker.blocks, tracker.queries, tracker.out_of_range);
    $display("checked %0d results with %0d mismatches", tracker.checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mcba_pkg.sv
rtl/mcba_bank.sv
rtl/multichannel_adc_block_averager_core.sv
test/multichannel_adc_block_averager_core_test.sv
